[sv/bhi_pkg.sv]
// ----------------------------------------------------------------------------
// bhi_pkg
// Shared types and constants of the bicosine height interpolator.
// ----------------------------------------------------------------------------
package bhi_pkg;

    localparam int MAP_SIDE_MAX_DEF = 128;
    localparam int HEIGHT_BITS_DEF  = 16;

    localparam logic       CFG_MAP_SIDE   = 1'b0;
    localparam logic       CFG_CELL_SHIFT = 1'b1;
    localparam logic [7:0] MAP_SIDE_RST   = 8'd128;
    localparam logic [2:0] CELL_SHIFT_RST = 3'd3;

    localparam logic [31:0] PI_Q28       = 32'd843314857;
    localparam logic [31:0] WRAP_Q28     = 32'd843314857;
    localparam logic [31:0] TWO_WRAP_Q28 = 32'd1686629714;
    localparam logic [31:0] K2_Q32       = 32'd2147483648;
    localparam logic [31:0] K4_Q32       = 32'd178956971;
    localparam logic [31:0] K6_Q32       = 32'd5965232;
    localparam logic [31:0] K8_Q32       = 32'd106522;
    localparam logic [31:0] K10_Q32      = 32'd1184;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP_A,
        ST_PREP_B,
        ST_MUL,
        ST_POST,
        ST_READ,
        ST_RCAP,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_WADDR,
        OP_ROW0,
        OP_ROW1,
        OP_ANG,
        OP_SQ,
        OP_H8,
        OP_H6,
        OP_H4,
        OP_H2,
        OP_MU,
        OP_BL_TOP,
        OP_BL_BOT,
        OP_BL_V
    } op_t;

endpackage

[sv/bhi_if.sv]
// ----------------------------------------------------------------------------
// bhi_if
// Valid/ready channels: input word and result word.
// ----------------------------------------------------------------------------
interface bhi_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic        [6:0]  cell_x;
    logic        [6:0]  cell_y;
    logic        [14:0] point_x;
    logic        [14:0] point_y;
    logic signed [15:0] height_in;

    modport source (output valid, kind, cell_x, cell_y, point_x, point_y, height_in,
                    input ready);
    modport sink   (input valid, kind, cell_x, cell_y, point_x, point_y, height_in,
                    output ready);
endinterface

interface bhi_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height_out;

    modport source (output valid, height_out, input ready);
    modport sink   (input valid, height_out, output ready);
endinterface

[sv/bicosine_height_interpolator_top.sv]
// ----------------------------------------------------------------------------
// bicosine_height_interpolator_top
// Height map with cosine-weighted bilinear lookup on one shared multiplier.
// ----------------------------------------------------------------------------
// Query: clamp and offset prep, multiplier passes and map reads, then output; write: address multiply, then store.
// One word in flight; next word accepted once the previous one is done.
// Rate set by 19 passes through the shared multiplier plus 4 map reads.
// Reset clears control and config (map_side 128, cell_shift 3).
// Height map has no reset; entries must be written before being read; the block does not enforce this.
module bicosine_height_interpolator_top #(
    parameter int MAP_SIDE_MAX = bhi_pkg::MAP_SIDE_MAX_DEF,
    parameter int HEIGHT_BITS  = bhi_pkg::HEIGHT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    bhi_in_if.sink     in_ch,
    bhi_out_if.source  out_ch
);

    localparam int SW    = $clog2(MAP_SIDE_MAX + 1);
    localparam int CW    = ((SW > 9) ? SW : 9) + 1;
    localparam int DEPTH = MAP_SIDE_MAX * MAP_SIDE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int HB    = HEIGHT_BITS;
    localparam logic signed [51:0] HMAX = (52'sd1 <<< (HEIGHT_BITS - 1)) - 52'sd1;
    localparam logic signed [51:0] HMIN = -HMAX - 52'sd1;

    bhi_pkg::state_t state_reg, state_next;
    bhi_pkg::op_t    op_reg, op_next;
    logic            axis_reg, axis_next;
    logic [1:0]      rd_idx_reg, rd_idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      map_side_reg;
    logic [2:0]      cell_shift_reg;

    logic                 kind_reg, kind_next;
    logic [6:0]           px_raw_reg, px_raw_next, py_raw_reg, py_raw_next;
    logic [14:0]          ptx_reg, ptx_next, pty_reg, pty_next;
    logic signed [15:0]   hin_reg, hin_next;
    logic [6:0]           cx_reg, cx_next, cy_reg, cy_next;
    logic [SW-1:0]        nx_reg, nx_next, ny_reg, ny_next;
    logic [16:0]          tx_reg, tx_next, ty_reg, ty_next;
    logic [AW-1:0]        row0_reg, row0_next, row1_reg, row1_next;
    logic [31:0]          ax_reg, ax_next, u_reg, u_next, acc_reg, acc_next;
    logic [17:0]          mx_reg, mx_next, my_reg, my_next;
    logic signed [HB-1:0] h_reg [4];
    logic signed [HB-1:0] h_next [4];
    logic signed [HB-1:0] top_reg, top_next, bot_reg, bot_next, res_reg, res_next;
    logic signed [15:0]   out_data_reg, out_data_next;
    logic signed [67:0]   prod_reg;
    logic signed [HB-1:0] rdata_reg;

    logic [HB-1:0]        mem [DEPTH];
    logic                 mem_we, mem_re;
    logic [AW-1:0]        waddr, raddr;
    logic [HB-1:0]        wdata;

    logic [CW-1:0]        side, ms, cxf, cyf, nxf, nyf;
    logic signed [33:0]   mul_a, mul_b;
    logic signed [67:0]   mul_p;
    logic signed [HB:0]   diff;
    logic [67:0]          rnd16, rnd28, rnd45;
    logic [31:0]          x_val, q28;
    logic signed [31:0]   hin32, res32;

    function automatic logic [16:0] t_of(input logic [14:0] pt, input logic [6:0] cr,
                                         input logic [2:0] sh);
        logic signed [16:0] off;
        logic [16:0]        span;
        logic [16:0]        offc;
        off  = signed'({2'b00, pt}) - signed'({2'b00, cr, 8'h00});
        span = 17'd256 << sh;
        if (off < 0)
            offc = '0;
        else if (17'(off) > span)
            offc = span;
        else
            offc = 17'(off);
        return offc << (4'd8 - {1'b0, sh});
    endfunction

    function automatic logic signed [HB-1:0] blend_post(input logic signed [67:0] p,
                                                        input logic signed [HB-1:0] y0);
        logic signed [67:0] pr;
        logic signed [51:0] r;
        logic signed [51:0] y;
        pr = p + 68'sd32768;
        r  = pr[67:16];
        y  = 52'(y0) + r;
        if (y > HMAX)
            y = HMAX;
        else if (y < HMIN)
            y = HMIN;
        return y[HB-1:0];
    endfunction

    always_comb
    begin
        ms = CW'(map_side_reg);
        if (ms < CW'(2))
            side = CW'(2);
        else if (ms > CW'(MAP_SIDE_MAX))
            side = CW'(MAP_SIDE_MAX);
        else
            side = ms;
    end

    always_comb
    begin
        diff  = '0;
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            bhi_pkg::OP_WADDR:
            begin
                mul_a = 34'(py_raw_reg);
                mul_b = 34'(side);
            end
            bhi_pkg::OP_ROW0:
            begin
                mul_a = 34'(cy_reg);
                mul_b = 34'(side);
            end
            bhi_pkg::OP_ROW1:
            begin
                mul_a = 34'(ny_reg);
                mul_b = 34'(side);
            end
            bhi_pkg::OP_ANG:
            begin
                mul_a = 34'(bhi_pkg::PI_Q28);
                mul_b = axis_reg ? 34'(ty_reg) : 34'(tx_reg);
            end
            bhi_pkg::OP_SQ:
            begin
                mul_a = 34'(ax_reg);
                mul_b = 34'(ax_reg);
            end
            bhi_pkg::OP_H8, bhi_pkg::OP_H6, bhi_pkg::OP_H4, bhi_pkg::OP_H2,
            bhi_pkg::OP_MU:
            begin
                mul_a = 34'(u_reg);
                mul_b = 34'(acc_reg);
            end
            bhi_pkg::OP_BL_TOP:
            begin
                diff  = (HB+1)'(h_reg[1]) - (HB+1)'(h_reg[0]);
                mul_a = 34'(diff);
                mul_b = 34'(mx_reg);
            end
            bhi_pkg::OP_BL_BOT:
            begin
                diff  = (HB+1)'(h_reg[3]) - (HB+1)'(h_reg[2]);
                mul_a = 34'(diff);
                mul_b = 34'(mx_reg);
            end
            bhi_pkg::OP_BL_V:
            begin
                diff  = (HB+1)'(bot_reg) - (HB+1)'(top_reg);
                mul_a = 34'(diff);
                mul_b = 34'(my_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign rnd16 = prod_reg + 68'd32768;
    assign rnd28 = prod_reg + (68'd1 << 27);
    assign rnd45 = prod_reg + (68'd1 << 44);
    assign x_val = rnd16[47:16];
    assign q28   = rnd28[59:28];
    assign hin32 = 32'(hin_reg);
    assign wdata = hin32[HB-1:0];
    assign waddr = prod_reg[AW-1:0] + AW'(px_raw_reg);

    always_comb
    begin
        case (rd_idx_reg)
            2'd0:    raddr = row0_reg + AW'(cx_reg);
            2'd1:    raddr = row0_reg + AW'(nx_reg);
            2'd2:    raddr = row1_reg + AW'(cx_reg);
            default: raddr = row1_reg + AW'(nx_reg);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        axis_next      = axis_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        kind_next      = kind_reg;
        px_raw_next    = px_raw_reg;
        py_raw_next    = py_raw_reg;
        ptx_next       = ptx_reg;
        pty_next       = pty_reg;
        hin_next       = hin_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        row0_next      = row0_reg;
        row1_next      = row1_reg;
        ax_next        = ax_reg;
        u_next         = u_reg;
        acc_next       = acc_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        h_next         = h_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        cxf            = CW'(cx_reg);
        cyf            = CW'(cy_reg);
        nxf            = cxf + (CW'(1) << cell_shift_reg);
        nyf            = cyf + (CW'(1) << cell_shift_reg);
        res32          = 32'(res_reg);

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            bhi_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    kind_next   = in_ch.kind;
                    px_raw_next = in_ch.cell_x;
                    py_raw_next = in_ch.cell_y;
                    ptx_next    = in_ch.point_x;
                    pty_next    = in_ch.point_y;
                    hin_next    = in_ch.height_in;
                    if (in_ch.kind)
                        state_next = bhi_pkg::ST_PREP_A;
                    else
                    begin
                        op_next    = bhi_pkg::OP_WADDR;
                        state_next = bhi_pkg::ST_MUL;
                    end
                end
            end
            bhi_pkg::ST_PREP_A:
            begin
                cx_next    = (CW'(px_raw_reg) > side - CW'(1)) ? 7'(side - CW'(1)) : px_raw_reg;
                cy_next    = (CW'(py_raw_reg) > side - CW'(1)) ? 7'(side - CW'(1)) : py_raw_reg;
                state_next = bhi_pkg::ST_PREP_B;
            end
            bhi_pkg::ST_PREP_B:
            begin
                nx_next    = (nxf >= side) ? SW'(cx_reg) : nxf[SW-1:0];
                ny_next    = (nyf >= side) ? SW'(cy_reg) : nyf[SW-1:0];
                tx_next    = t_of(ptx_reg, cx_reg, cell_shift_reg);
                ty_next    = t_of(pty_reg, cy_reg, cell_shift_reg);
                op_next    = bhi_pkg::OP_ROW0;
                state_next = bhi_pkg::ST_MUL;
            end
            bhi_pkg::ST_MUL:
            begin
                state_next = bhi_pkg::ST_POST;
            end
            bhi_pkg::ST_POST:
            begin
                state_next = bhi_pkg::ST_MUL;
                case (op_reg)
                    bhi_pkg::OP_WADDR:
                    begin
                        mem_we     = (CW'(px_raw_reg) < side) && (CW'(py_raw_reg) < side);
                        state_next = bhi_pkg::ST_IDLE;
                    end
                    bhi_pkg::OP_ROW0:
                    begin
                        row0_next = prod_reg[AW-1:0];
                        op_next   = bhi_pkg::OP_ROW1;
                    end
                    bhi_pkg::OP_ROW1:
                    begin
                        row1_next = prod_reg[AW-1:0];
                        axis_next = 1'b0;
                        op_next   = bhi_pkg::OP_ANG;
                    end
                    bhi_pkg::OP_ANG:
                    begin
                        ax_next = (x_val > bhi_pkg::WRAP_Q28) ?
                                  bhi_pkg::TWO_WRAP_Q28 - x_val : x_val;
                        op_next = bhi_pkg::OP_SQ;
                    end
                    bhi_pkg::OP_SQ:
                    begin
                        u_next   = q28;
                        acc_next = bhi_pkg::K10_Q32;
                        op_next  = bhi_pkg::OP_H8;
                    end
                    bhi_pkg::OP_H8:
                    begin
                        acc_next = bhi_pkg::K8_Q32 - q28;
                        op_next  = bhi_pkg::OP_H6;
                    end
                    bhi_pkg::OP_H6:
                    begin
                        acc_next = bhi_pkg::K6_Q32 - q28;
                        op_next  = bhi_pkg::OP_H4;
                    end
                    bhi_pkg::OP_H4:
                    begin
                        acc_next = bhi_pkg::K4_Q32 - q28;
                        op_next  = bhi_pkg::OP_H2;
                    end
                    bhi_pkg::OP_H2:
                    begin
                        acc_next = bhi_pkg::K2_Q32 - q28;
                        op_next  = bhi_pkg::OP_MU;
                    end
                    bhi_pkg::OP_MU:
                    begin
                        if (!axis_reg)
                        begin
                            mx_next   = rnd45[62:45];
                            axis_next = 1'b1;
                            op_next   = bhi_pkg::OP_ANG;
                        end
                        else
                        begin
                            my_next     = rnd45[62:45];
                            rd_idx_next = 2'd0;
                            state_next  = bhi_pkg::ST_READ;
                        end
                    end
                    bhi_pkg::OP_BL_TOP:
                    begin
                        top_next = blend_post(prod_reg, h_reg[0]);
                        op_next  = bhi_pkg::OP_BL_BOT;
                    end
                    bhi_pkg::OP_BL_BOT:
                    begin
                        bot_next = blend_post(prod_reg, h_reg[2]);
                        op_next  = bhi_pkg::OP_BL_V;
                    end
                    bhi_pkg::OP_BL_V:
                    begin
                        res_next   = blend_post(prod_reg, top_reg);
                        state_next = bhi_pkg::ST_OUT;
                    end
                    default:
                    begin
                        state_next = bhi_pkg::ST_IDLE;
                    end
                endcase
            end
            bhi_pkg::ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = bhi_pkg::ST_RCAP;
            end
            bhi_pkg::ST_RCAP:
            begin
                h_next[rd_idx_reg] = rdata_reg;
                if (rd_idx_reg == 2'd3)
                begin
                    op_next    = bhi_pkg::OP_BL_TOP;
                    state_next = bhi_pkg::ST_MUL;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 2'd1;
                    state_next  = bhi_pkg::ST_READ;
                end
            end
            bhi_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res32[15:0];
                    state_next     = bhi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bhi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bhi_pkg::ST_IDLE;
            op_reg         <= bhi_pkg::OP_WADDR;
            axis_reg       <= 1'b0;
            rd_idx_reg     <= 2'd0;
            out_valid_reg  <= 1'b0;
            map_side_reg   <= bhi_pkg::MAP_SIDE_RST;
            cell_shift_reg <= bhi_pkg::CELL_SHIFT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            axis_reg      <= axis_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bhi_pkg::CFG_MAP_SIDE:   map_side_reg   <= cfg_data;
                    bhi_pkg::CFG_CELL_SHIFT: cell_shift_reg <= cfg_data[2:0];
                    default:                 map_side_reg   <= map_side_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        px_raw_reg   <= px_raw_next;
        py_raw_reg   <= py_raw_next;
        ptx_reg      <= ptx_next;
        pty_reg      <= pty_next;
        hin_reg      <= hin_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        row0_reg     <= row0_next;
        row1_reg     <= row1_next;
        ax_reg       <= ax_next;
        u_reg        <= u_next;
        acc_reg      <= acc_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        h_reg        <= h_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        prod_reg     <= mul_p;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    assign in_ch.ready       = (state_reg == bhi_pkg::ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.height_out = out_data_reg;

`ifndef SYNTHESIS
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !in_ch.kind) |=> !$rose(out_valid_reg))
        else $error("write word produced a result");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == bhi_pkg::ST_OUT))
        else $error("result raised outside output state");

    a_horner_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhi_pkg::ST_POST && op_reg == bhi_pkg::OP_H2)
        |=> (acc_reg <= bhi_pkg::K2_Q32))
        else $error("polynomial accumulator out of range");

    a_query_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bhi_pkg::ST_READ) |-> kind_reg)
        else $error("map read during a write word");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bicosine height interpolator: map writes and
// cosine-weighted queries are predicted in a local model and compared.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic               kind;
        logic        [6:0]  cell_x;
        logic        [6:0]  cell_y;
        logic        [14:0] point_x;
        logic        [14:0] point_y;
        logic signed [15:0] height_in;
    } word_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    bhi_in_if  in_ch ();
    bhi_out_if out_ch ();

    bicosine_height_interpolator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    word_t              pending_words[$];
    logic signed [15:0] expected_heights[$];
    logic signed [15:0] height_map[bhi_pkg::MAP_SIDE_MAX_DEF*bhi_pkg::MAP_SIDE_MAX_DEF];
    bit                 written[bhi_pkg::MAP_SIDE_MAX_DEF*bhi_pkg::MAP_SIDE_MAX_DEF];
    int                 side_m;
    int                 shift_m;
    int                 mismatches;
    int                 idle_cycles;
    int                 gap_left;
    int                 stall_left;
    bit                 quiet;
    bit                 in_taken;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint cos_mu(longint t16);
        longint x;
        longint u;
        longint acc;
        x = (843314857 * t16 + 32768) >>> 16;
        if (x > 843314857)
            x = x - 2 * 64'sd843314857;
        if (x < 0)
            x = -x;
        u = (x * x + (64'sd1 << 27)) >>> 28;
        acc = 1184;
        acc = 106522 - ((u * acc + (64'sd1 << 27)) >>> 28);
        acc = 5965232 - ((u * acc + (64'sd1 << 27)) >>> 28);
        acc = 178956971 - ((u * acc + (64'sd1 << 27)) >>> 28);
        acc = 64'sd2147483648 - ((u * acc + (64'sd1 << 27)) >>> 28);
        return (u * acc + (64'sd1 << 44)) >>> 45;
    endfunction

    function automatic longint mix(longint y0, longint y1, longint mu);
        longint p;
        longint r;
        longint y;
        p = (y1 - y0) * mu + 32768;
        r = (p >= 0) ? (p >>> 16) : -((-p + 65535) >>> 16);
        y = y0 + r;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return y;
    endfunction

    function automatic longint offset_mu(longint pt, longint corner, int sh);
        longint off;
        longint span;
        off = pt - corner * 256;
        span = longint'(256) << sh;
        if (off < 0)
            off = 0;
        if (off > span)
            off = span;
        return cos_mu(off << (8 - sh));
    endfunction

    function automatic longint node_h(int col, int row);
        return height_map[row * side_m + col];
    endfunction

    task automatic predict_height(word_t w);
        int     cx;
        int     cy;
        int     nx;
        int     ny;
        longint mx;
        longint my;
        longint top;
        longint bot;
        cx = w.cell_x;
        cy = w.cell_y;
        if (w.kind == 1'b0)
        begin
            if (cx < side_m && cy < side_m)
            begin
                height_map[cy * side_m + cx] = w.height_in;
            end
            return;
        end
        if (cx > side_m - 1)
            cx = side_m - 1;
        if (cy > side_m - 1)
            cy = side_m - 1;
        nx = cx + (1 << shift_m);
        ny = cy + (1 << shift_m);
        if (nx >= side_m)
            nx = cx;
        if (ny >= side_m)
            ny = cy;
        mx = offset_mu(w.point_x, cx, shift_m);
        my = offset_mu(w.point_y, cy, shift_m);
        top = mix(node_h(cx, cy), node_h(nx, cy), mx);
        bot = mix(node_h(cx, ny), node_h(nx, ny), mx);
        expected_heights.push_back(16'(mix(top, bot, my)));
    endtask

    // driver
    always @(negedge clk)
    begin
        word_t w;
        if (rst_n)
        begin
            if (in_taken)
                in_taken <= 1'b0;
            if (!in_ch.valid || in_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                    begin
                        gap_left <= $urandom_range(0, 17);
                        in_ch.valid <= 1'b0;
                    end
                    else
                    begin
                        w = pending_words[0];
                        in_ch.valid     <= 1'b1;
                        in_ch.kind      <= w.kind;
                        in_ch.cell_x    <= w.cell_x;
                        in_ch.cell_y    <= w.cell_y;
                        in_ch.point_x   <= w.point_x;
                        in_ch.point_y   <= w.point_y;
                        in_ch.height_in <= w.height_in;
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(0, 17);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                predict_height(pending_words.pop_front());
                in_taken <= 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_heights.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected word: height_out=%0d", out_ch.height_out);
                end
                else if (expected_heights[0] !== out_ch.height_out)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("height_out mismatch: expected %0d actual %0d",
                                 expected_heights[0], out_ch.height_out);
                    void'(expected_heights.pop_front());
                end
                else
                    void'(expected_heights.pop_front());
            end
            if (idle_cycles > 5000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_ch.valid || expected_heights.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == bhi_pkg::CFG_MAP_SIDE)
        begin
            side_m = val;
            if (side_m < 2)
                side_m = 2;
            if (side_m > bhi_pkg::MAP_SIDE_MAX_DEF)
                side_m = bhi_pkg::MAP_SIDE_MAX_DEF;
        end
        else
            shift_m = val[2:0];
    endtask

    function automatic word_t map_write(int x, int y, logic signed [15:0] h);
        word_t w;
        w.kind = 1'b0;
        w.cell_x = x;
        w.cell_y = y;
        w.point_x = 15'($urandom);
        w.point_y = 15'($urandom);
        w.height_in = h;
        if (x < side_m && y < side_m)
            written[y * side_m + x] = 1'b1;
        return w;
    endfunction

    // fill the top-left lim x lim nodes of the current map
    task automatic fill_map(bit extremes, int lim);
        int r;
        int c;
        logic signed [15:0] h;
        for (r = 0; r < lim; r++)
            for (c = 0; c < lim; c++)
            begin
                if (extremes)
                    h = ((r + c) % 2) ? 16'sh7fff : 16'sh8000;
                else
                    h = 16'($urandom);
                pending_words.push_back(map_write(c, r, h));
            end
    endtask

    function automatic word_t query(int side_lim);
        word_t w;
        int    span;
        w.kind = 1'b1;
        w.cell_x = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, side_lim - 1));
        w.cell_y = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, side_lim - 1));
        span = 256 << shift_m;
        if ($urandom_range(0, 5) == 0)
        begin
            w.point_x = 15'($urandom);
            w.point_y = 15'($urandom);
        end
        else
        begin
            w.point_x = 15'(w.cell_x * 256 + $urandom_range(0, span));
            w.point_y = 15'(w.cell_y * 256 + $urandom_range(0, span));
        end
        w.height_in = 16'($urandom);
        return w;
    endfunction

    // true when all four nodes that the query reads have been written
    function automatic bit query_ok(word_t w);
        int cx;
        int cy;
        int nx;
        int ny;
        cx = w.cell_x;
        cy = w.cell_y;
        if (cx > side_m - 1)
            cx = side_m - 1;
        if (cy > side_m - 1)
            cy = side_m - 1;
        nx = cx + (1 << shift_m);
        ny = cy + (1 << shift_m);
        if (nx >= side_m)
            nx = cx;
        if (ny >= side_m)
            ny = cy;
        return written[cy * side_m + cx] && written[cy * side_m + nx]
            && written[ny * side_m + cx] && written[ny * side_m + nx];
    endfunction

    task automatic run_phase(int side, int sh, int n, bit extremes, int lim);
        int    i;
        int    k;
        int    lim_m;
        bit    found;
        word_t w;
        write_reg(bhi_pkg::CFG_MAP_SIDE, 8'(side));
        write_reg(bhi_pkg::CFG_CELL_SHIFT, 3'(sh));
        lim_m = (lim < side_m) ? lim : side_m;
        fill_map(extremes, lim_m);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                w = map_write($urandom_range(0, 127), $urandom_range(0, 127), 16'($urandom));
                pending_words.push_back(w);
            end
            else
            begin
                found = 1'b0;
                for (k = 0; k < 64 && !found; k++)
                begin
                    w = query(lim_m);
                    found = query_ok(w);
                end
                if (found)
                    pending_words.push_back(w);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        word_t w;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bhi_pkg::CFG_MAP_SIDE;
        cfg_data = 8'd0;
        in_ch.valid = 1'b0;
        in_ch.kind = 1'b0;
        in_ch.cell_x = 7'd0;
        in_ch.cell_y = 7'd0;
        in_ch.point_x = 15'd0;
        in_ch.point_y = 15'd0;
        in_ch.height_in = 16'sd0;
        out_ch.ready = 1'b0;
        side_m = 128;
        shift_m = 3;
        mismatches = 0;
        idle_cycles = 0;
        gap_left = 0;
        stall_left = 0;
        quiet = 1'b0;
        in_taken = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: smallest map, extreme heights, corners, saturating points
        write_reg(bhi_pkg::CFG_MAP_SIDE, 8'd0);
        write_reg(bhi_pkg::CFG_CELL_SHIFT, 3'd0);
        fill_map(1'b1, side_m);
        pending_words.push_back(map_write(127, 127, 16'sd5));
        w = query(2);
        w.cell_x = 0; w.cell_y = 0; w.point_x = 0; w.point_y = 0;
        pending_words.push_back(w);
        w.point_x = 15'h7fff; w.point_y = 15'h7fff;
        pending_words.push_back(w);
        w.point_x = 128; w.point_y = 64;
        pending_words.push_back(w);
        w.cell_x = 7'h7f; w.cell_y = 7'h7f; w.point_x = 300; w.point_y = 0;
        pending_words.push_back(w);
        w.cell_x = 1; w.cell_y = 0; w.point_x = 256 + 200; w.point_y = 100;
        pending_words.push_back(w);
        wait_drained();

        run_phase(8, 7, 40, 1'b1, 8);
        run_phase(5, 2, 80, 1'b0, 5);
        run_phase(2, 6, 40, 1'b0, 2);
        run_phase(255, 1, 60, 1'b0, 6);
        quiet = 1'b1;
        run_phase(12, 1, 100, 1'b0, 12);

        if (mismatches == 0 && expected_heights.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
